>>> rtl/core/hptc_pkg.sv
// ----------------------------------------------------------------------------
// hptc_pkg
// Shared types and constants for the heading pid turn controller.
// ----------------------------------------------------------------------------
package hptc_pkg;

  localparam int FRAC_BITS   = 24;
  localparam int HALF_TURN   = 18000;
  localparam int FULL_TURN   = 36000;
  // offset that keeps the wrap input positive for every bit pattern
  localparam int WRAP_BIAS   = 4 * FULL_TURN;
  localparam int WRAP_STEPS  = 6;

  localparam int HEADING_W   = 16;
  localparam int TARGET_W    = 17;
  localparam int GAIN_W      = 32;
  localparam int TOL_W       = 15;
  localparam int ERR_W       = 16;
  localparam int DERIV_W     = 17;
  localparam int INTEG_W     = 48;
  localparam int DRIVE_W     = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 5;

  localparam logic [TARGET_W-1:0] TARGET_RST = '0;
  localparam logic [GAIN_W-1:0]   KP_RST     = 32'd8388608;
  localparam logic [GAIN_W-1:0]   KI_RST     = 32'd1678;
  localparam logic [GAIN_W-1:0]   KD_RST     = 32'd33554;
  localparam logic [TOL_W-1:0]    ERR_TOL_RST  = 15'd200;
  localparam logic [TOL_W-1:0]    RATE_TOL_RST = 15'd20;

  typedef enum logic [2:0] {
    REG_TARGET    = 3'd0,
    REG_KP        = 3'd1,
    REG_KI        = 3'd2,
    REG_KD        = 3'd3,
    REG_ERR_TOL   = 3'd4,
    REG_RATE_TOL  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [TARGET_W-1:0] target_angle;
    logic [GAIN_W-1:0]          kp;
    logic [GAIN_W-1:0]          ki;
    logic [GAIN_W-1:0]          kd;
    logic [TOL_W-1:0]           err_tol;
    logic [TOL_W-1:0]           rate_tol;
  } cfg_regs_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [DERIV_W-1:0] deriv;
    logic signed [INTEG_W-1:0] integ;
    logic                      settled;
  } trk_result_t;

endpackage

>>> rtl/core/heading_pid_turn_controller_top.sv
// ----------------------------------------------------------------------------
// heading_pid_turn_controller_top
// Heading pid turn controller with angle wrap and apb register port.
// ----------------------------------------------------------------------------
// usage:
//   in_* carries one heading sample per item (valid/stall); out_* returns
//   one result per item: left and right drive, wrapped error, settled flag.
//   gains, target and tolerances sit in apb registers at byte address 4*i;
//   write them only while no item is in flight.
// timing:
//   five register stages (input, tracking, products, low sum, result). one item
//   is taken every cycle while in_stall is low; the loop state (integral,
//   previous error) closes in the tracking stage.
// stall:
//   a stalled result holds in the result register; earlier stages keep
//   filling bubbles, and in_stall rises only once every stage holds an item.
// reset:
//   rst_n clears all valids, the integral and the previous error, and loads
//   the register defaults.
// ----------------------------------------------------------------------------
module heading_pid_turn_controller_top (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic [hptc_pkg::HEADING_W-1:0]           in_heading,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [hptc_pkg::DRIVE_W-1:0]      out_left_drive,
  output logic signed [hptc_pkg::DRIVE_W-1:0]      out_right_drive,
  output logic signed [hptc_pkg::ERR_W-1:0]        out_wrapped_error,
  output logic                                     out_settled,
  input  logic                                     cfg_psel,
  input  logic                                     cfg_penable,
  input  logic                                     cfg_pwrite,
  input  logic [hptc_pkg::CFG_ADDR_W-1:0]          cfg_paddr,
  input  logic [hptc_pkg::CFG_DATA_W-1:0]          cfg_pwdata,
  output logic [hptc_pkg::CFG_DATA_W-1:0]          cfg_prdata,
  output logic                                     cfg_pready
);

  hptc_pkg::cfg_regs_t               cfg_r;
  hptc_pkg::cfg_reg_t                reg_sel;
  logic                              cfg_wr;

  logic                              a_vld_r;
  logic [hptc_pkg::HEADING_W-1:0]    a_heading_r;
  logic                              a_ready;

  logic                              trk_ready;
  logic                              trk_vld;
  logic                              drv_ready;
  hptc_pkg::trk_result_t             trk_res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = hptc_pkg::cfg_reg_t'(cfg_paddr[hptc_pkg::CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_angle <= hptc_pkg::TARGET_RST;
      cfg_r.kp           <= hptc_pkg::KP_RST;
      cfg_r.ki           <= hptc_pkg::KI_RST;
      cfg_r.kd           <= hptc_pkg::KD_RST;
      cfg_r.err_tol      <= hptc_pkg::ERR_TOL_RST;
      cfg_r.rate_tol     <= hptc_pkg::RATE_TOL_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        hptc_pkg::REG_TARGET:   cfg_r.target_angle <= cfg_pwdata[hptc_pkg::TARGET_W-1:0];
        hptc_pkg::REG_KP:       cfg_r.kp           <= cfg_pwdata[hptc_pkg::GAIN_W-1:0];
        hptc_pkg::REG_KI:       cfg_r.ki           <= cfg_pwdata[hptc_pkg::GAIN_W-1:0];
        hptc_pkg::REG_KD:       cfg_r.kd           <= cfg_pwdata[hptc_pkg::GAIN_W-1:0];
        hptc_pkg::REG_ERR_TOL:  cfg_r.err_tol      <= cfg_pwdata[hptc_pkg::TOL_W-1:0];
        hptc_pkg::REG_RATE_TOL: cfg_r.rate_tol     <= cfg_pwdata[hptc_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      hptc_pkg::REG_TARGET:   cfg_prdata = hptc_pkg::CFG_DATA_W'(cfg_r.target_angle);
      hptc_pkg::REG_KP:       cfg_prdata = cfg_r.kp;
      hptc_pkg::REG_KI:       cfg_prdata = cfg_r.ki;
      hptc_pkg::REG_KD:       cfg_prdata = cfg_r.kd;
      hptc_pkg::REG_ERR_TOL:  cfg_prdata = hptc_pkg::CFG_DATA_W'(cfg_r.err_tol);
      hptc_pkg::REG_RATE_TOL: cfg_prdata = hptc_pkg::CFG_DATA_W'(cfg_r.rate_tol);
      default:                cfg_prdata = '0;
    endcase
  end

  // input register
  assign a_ready  = !a_vld_r || trk_ready;
  assign in_stall = !a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (a_ready) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      a_heading_r <= in_heading;
    end
  end

  hptc_track u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (a_vld_r),
    .in_ready   (trk_ready),
    .in_heading (a_heading_r),
    .out_valid  (trk_vld),
    .out_ready  (drv_ready),
    .out_res    (trk_res)
  );

  hptc_drive u_drive (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_valid          (trk_vld),
    .in_ready          (drv_ready),
    .in_res            (trk_res),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_left_drive    (out_left_drive),
    .out_right_drive   (out_right_drive),
    .out_wrapped_error (out_wrapped_error),
    .out_settled       (out_settled)
  );

`ifndef SYNTH
  logic [hptc_pkg::ERR_W:0] chk_err_abs;
  assign chk_err_abs = out_wrapped_error[hptc_pkg::ERR_W-1]
                     ? (hptc_pkg::ERR_W+1)'(-$signed({1'b1, out_wrapped_error}))
                     : {1'b0, out_wrapped_error};

  // wrapped error always lands in the half-open half-turn range
  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_wrapped_error >= -16'sd18000) && (out_wrapped_error <= 16'sd17999))
    else $error("wrapped error out of range");

  // settled only inside the error tolerance
  a_settled_tol: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_settled |-> chk_err_abs <= (hptc_pkg::ERR_W+1)'(cfg_r.err_tol))
    else $error("settled outside error tolerance");

  // right drive mirrors left drive, except where the sum runs into a rail
  a_right_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_right_drive == -out_left_drive)
               || ((out_left_drive == {1'b1, {(hptc_pkg::DRIVE_W-1){1'b0}}})
                   && (out_right_drive == {1'b0, {(hptc_pkg::DRIVE_W-1){1'b1}}}))
               || ((out_left_drive == {1'b0, {(hptc_pkg::DRIVE_W-1){1'b1}}})
                   && (out_right_drive == {1'b1, {(hptc_pkg::DRIVE_W-1){1'b0}}})))
    else $error("right drive does not mirror left drive");
`endif

endmodule

>>> rtl/core/hptc_track.sv
// ----------------------------------------------------------------------------
// hptc_track
// Angle wrap, saturating integral, derivative and settle check; holds the
// loop state and registers one tracked item per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module hptc_track (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  hptc_pkg::cfg_regs_t                  cfg,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [hptc_pkg::HEADING_W-1:0]       in_heading,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output hptc_pkg::trk_result_t                out_res
);

  localparam int XW = 20;
  localparam int RW = 18;

  logic                                     b_vld_r;
  hptc_pkg::trk_result_t                    b_res_r;
  logic signed [hptc_pkg::INTEG_W-1:0]      integ_r;
  logic signed [hptc_pkg::ERR_W-1:0]        prev_r;

  logic signed [XW-1:0]                     wrap_sum;
  logic [RW-1:0]                            wrap_x;
  logic [RW-1:0]                            wrap_sub;
  logic [RW-1:0]                            wrap_r;
  logic signed [hptc_pkg::ERR_W:0]          err_wide;
  logic signed [hptc_pkg::ERR_W-1:0]        err_nxt;
  logic signed [hptc_pkg::DERIV_W-1:0]      deriv_nxt;
  logic signed [hptc_pkg::INTEG_W:0]        isum;
  logic signed [hptc_pkg::INTEG_W-1:0]      integ_nxt;
  logic [hptc_pkg::ERR_W:0]                 err_abs;
  logic [hptc_pkg::DERIV_W:0]               deriv_abs;
  logic                                     settled_nxt;
  logic                                     fire;

  assign in_ready  = !b_vld_r || out_ready;
  assign fire      = in_valid && in_ready;
  assign out_valid = b_vld_r;
  assign out_res   = b_res_r;

  always_comb begin
    wrap_sum = XW'(cfg.target_angle) - $signed({4'b0, in_heading})
             + XW'(hptc_pkg::HALF_TURN + hptc_pkg::WRAP_BIAS);
    wrap_x   = wrap_sum[RW-1:0];
    // reduce modulo one turn against the handful of possible multiples
    wrap_sub = '0;
    for (int k = 1; k <= hptc_pkg::WRAP_STEPS; k++) begin
      if (wrap_x >= RW'(k * hptc_pkg::FULL_TURN)) begin
        wrap_sub = RW'(k * hptc_pkg::FULL_TURN);
      end
    end
    wrap_r   = wrap_x - wrap_sub;
    err_wide = $signed({1'b0, wrap_r[hptc_pkg::ERR_W-1:0]})
             - (hptc_pkg::ERR_W+1)'(hptc_pkg::HALF_TURN);
    err_nxt  = err_wide[hptc_pkg::ERR_W-1:0];

    deriv_nxt = $signed({err_nxt[hptc_pkg::ERR_W-1], err_nxt})
              - $signed({prev_r[hptc_pkg::ERR_W-1], prev_r});

    isum = $signed({integ_r[hptc_pkg::INTEG_W-1], integ_r})
         + (hptc_pkg::INTEG_W+1)'(err_nxt);
    if (isum[hptc_pkg::INTEG_W] != isum[hptc_pkg::INTEG_W-1]) begin
      integ_nxt = {isum[hptc_pkg::INTEG_W], {(hptc_pkg::INTEG_W-1){!isum[hptc_pkg::INTEG_W]}}};
    end else begin
      integ_nxt = isum[hptc_pkg::INTEG_W-1:0];
    end

    err_abs   = err_nxt[hptc_pkg::ERR_W-1]
              ? (hptc_pkg::ERR_W+1)'(-$signed({1'b1, err_nxt}))
              : {1'b0, err_nxt};
    deriv_abs = deriv_nxt[hptc_pkg::DERIV_W-1]
              ? (hptc_pkg::DERIV_W+1)'(-$signed({1'b1, deriv_nxt}))
              : {1'b0, deriv_nxt};
    settled_nxt = (err_abs <= (hptc_pkg::ERR_W+1)'(cfg.err_tol))
               && (deriv_abs <= (hptc_pkg::DERIV_W+1)'(cfg.rate_tol));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
      integ_r <= '0;
      prev_r  <= '0;
    end else begin
      if (in_ready) begin
        b_vld_r <= in_valid;
      end
      if (fire) begin
        // a settled item starts the next turn from a clean state
        integ_r <= settled_nxt ? '0 : integ_nxt;
        prev_r  <= settled_nxt ? '0 : err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      b_res_r.err     <= err_nxt;
      b_res_r.deriv   <= deriv_nxt;
      b_res_r.integ   <= integ_nxt;
      b_res_r.settled <= settled_nxt;
    end
  end

endmodule

>>> rtl/core/hptc_drive.sv
// ----------------------------------------------------------------------------
// hptc_drive
// Pipelined gain products, fixed-point sum, floor shift and saturation of
// the left and right drive commands.
// ----------------------------------------------------------------------------
module hptc_drive (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  hptc_pkg::cfg_regs_t                    cfg,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  hptc_pkg::trk_result_t                  in_res,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [hptc_pkg::DRIVE_W-1:0]    out_left_drive,
  output logic signed [hptc_pkg::DRIVE_W-1:0]    out_right_drive,
  output logic signed [hptc_pkg::ERR_W-1:0]      out_wrapped_error,
  output logic                                   out_settled
);

  localparam int FB    = hptc_pkg::FRAC_BITS;
  localparam int GW    = hptc_pkg::GAIN_W;
  localparam int IW    = hptc_pkg::INTEG_W;
  localparam int ILO_W = GW + FB;
  localparam int IHI_W = GW + 1 + IW - FB;
  localparam int PE_W  = GW + 1 + hptc_pkg::ERR_W;
  localparam int PD_W  = GW + 1 + hptc_pkg::DERIV_W;
  localparam int LOW_W = ILO_W + 2;
  localparam int LSH_W = LOW_W - FB;
  localparam int SUM_W = LOW_W;
  localparam int DW    = hptc_pkg::DRIVE_W;

  // stage c: products
  logic                              c_vld_r;
  logic [ILO_W-1:0]                  c_ilo_r;
  logic signed [IHI_W-1:0]           c_ihi_r;
  logic signed [PE_W-1:0]            c_pe_r;
  logic signed [PD_W-1:0]            c_pd_r;
  logic signed [hptc_pkg::ERR_W-1:0] c_err_r;
  logic                              c_set_r;
  // stage d: low part summed and floor shifted
  logic                              d_vld_r;
  logic signed [LSH_W-1:0]           d_lsh_r;
  logic signed [IHI_W-1:0]           d_ihi_r;
  logic signed [hptc_pkg::ERR_W-1:0] d_err_r;
  logic                              d_set_r;
  // stage e: result register
  logic                              e_vld_r;
  logic signed [DW-1:0]              e_left_r;
  logic signed [DW-1:0]              e_right_r;
  logic signed [hptc_pkg::ERR_W-1:0] e_err_r;
  logic                              e_set_r;

  logic                              c_ready;
  logic                              d_ready;
  logic                              e_ready;

  logic signed [GW:0]                kp_s;
  logic signed [GW:0]                ki_s;
  logic signed [GW:0]                kd_s;
  logic signed [IW-FB-1:0]           ihi_s;
  logic [FB-1:0]                     ilo_u;
  logic signed [LOW_W-1:0]           low_sum;
  logic signed [SUM_W-1:0]           full_sum;
  logic signed [SUM_W:0]             neg_sum;
  logic signed [DW-1:0]              left_nxt;
  logic signed [DW-1:0]              right_nxt;

  assign e_ready  = !e_vld_r || !out_stall;
  assign d_ready  = !d_vld_r || e_ready;
  assign c_ready  = !c_vld_r || d_ready;
  assign in_ready = c_ready;

  assign out_valid         = e_vld_r;
  assign out_left_drive    = e_left_r;
  assign out_right_drive   = e_right_r;
  assign out_wrapped_error = e_err_r;
  assign out_settled       = e_set_r;

  always_comb begin
    kp_s  = $signed({1'b0, cfg.kp});
    ki_s  = $signed({1'b0, cfg.ki});
    kd_s  = $signed({1'b0, cfg.kd});
    ihi_s = in_res.integ[IW-1:FB];
    ilo_u = in_res.integ[FB-1:0];

    low_sum = $signed({2'b00, c_ilo_r}) + LOW_W'(c_pe_r) + LOW_W'(c_pd_r);

    full_sum = SUM_W'(d_ihi_r) + SUM_W'(d_lsh_r);
    neg_sum  = -((SUM_W+1)'(full_sum));

    if (full_sum > SUM_W'(2**(DW-1) - 1)) begin
      left_nxt = {1'b0, {(DW-1){1'b1}}};
    end else if (full_sum < -SUM_W'(2**(DW-1))) begin
      left_nxt = {1'b1, {(DW-1){1'b0}}};
    end else begin
      left_nxt = full_sum[DW-1:0];
    end

    if (neg_sum > (SUM_W+1)'(2**(DW-1) - 1)) begin
      right_nxt = {1'b0, {(DW-1){1'b1}}};
    end else if (neg_sum < -(SUM_W+1)'(2**(DW-1))) begin
      right_nxt = {1'b1, {(DW-1){1'b0}}};
    end else begin
      right_nxt = neg_sum[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
    end else begin
      if (c_ready) begin
        c_vld_r <= in_valid;
      end
      if (d_ready) begin
        d_vld_r <= c_vld_r;
      end
      if (e_ready) begin
        e_vld_r <= d_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && c_ready) begin
      // integral split in two halves so each product stays near 32x24
      c_ilo_r <= cfg.ki * ilo_u;
      c_ihi_r <= ki_s * ihi_s;
      c_pe_r  <= kp_s * in_res.err;
      c_pd_r  <= kd_s * in_res.deriv;
      c_err_r <= in_res.err;
      c_set_r <= in_res.settled;
    end
    if (c_vld_r && d_ready) begin
      d_lsh_r <= low_sum[LOW_W-1:FB];
      d_ihi_r <= c_ihi_r;
      d_err_r <= c_err_r;
      d_set_r <= c_set_r;
    end
    if (d_vld_r && e_ready) begin
      e_left_r  <= left_nxt;
      e_right_r <= right_nxt;
      e_err_r   <= d_err_r;
      e_set_r   <= d_set_r;
    end
  end

endmodule

>>> bench/hptc_drive_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hptc_drive_checker
// Watches the heading, result and register ports of the turn controller,
// predicts every drive result from its own copy of the loop state and the
// registers, and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module hptc_drive_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [hptc_pkg::HEADING_W-1:0]      in_heading,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [hptc_pkg::DRIVE_W-1:0] out_left_drive,
  input  logic signed [hptc_pkg::DRIVE_W-1:0] out_right_drive,
  input  logic signed [hptc_pkg::ERR_W-1:0]   out_wrapped_error,
  input  logic                                out_settled,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [hptc_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [hptc_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  input  logic                                cfg_pready,
  output int                                  mismatch_count,
  output int                                  pending_count
);

  import hptc_pkg::*;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] left;
    logic signed [DRIVE_W-1:0] right;
    logic signed [ERR_W-1:0]   werr;
    logic                      settled;
  } drive_result_t;

  localparam longint INTEG_MAX = (longint'(1) <<< (INTEG_W - 1)) - 1;
  localparam longint INTEG_MIN = -INTEG_MAX - 1;
  localparam logic signed [127:0] DRIVE_MAX = 128'sd2147483647;
  localparam logic signed [127:0] DRIVE_MIN = -128'sd2147483648;

  longint            target_cd = 0;
  logic [GAIN_W-1:0] kp = KP_RST;
  logic [GAIN_W-1:0] ki = KI_RST;
  logic [GAIN_W-1:0] kd = KD_RST;
  longint            err_tol = ERR_TOL_RST;
  longint            rate_tol = RATE_TOL_RST;
  longint            integral = 0;
  longint            last_err = 0;
  drive_result_t     expected_drives[$];
  int                result_idx = 0;

  function automatic logic signed [DRIVE_W-1:0] sat_drive(input logic signed [127:0] v);
    if (v > DRIVE_MAX) return DRIVE_MAX[DRIVE_W-1:0];
    if (v < DRIVE_MIN) return DRIVE_MIN[DRIVE_W-1:0];
    return v[DRIVE_W-1:0];
  endfunction

  // one control tick: wrap, integrate, differentiate, weigh, settle
  function automatic drive_result_t predict_drive(input logic [HEADING_W-1:0] heading);
    longint              hd, pos, err, deriv, integ;
    logic signed [127:0] kp_w, ki_w, kd_w, e_w, i_w, d_w, sum;
    drive_result_t       res;
    hd = heading;
    pos = (target_cd - hd + HALF_TURN) % FULL_TURN;
    if (pos < 0) pos += FULL_TURN;
    err = pos - HALF_TURN;
    integ = integral + err;
    if (integ > INTEG_MAX) integ = INTEG_MAX;
    if (integ < INTEG_MIN) integ = INTEG_MIN;
    deriv = err - last_err;
    kp_w = {96'd0, kp};
    ki_w = {96'd0, ki};
    kd_w = {96'd0, kd};
    e_w = err;
    i_w = integ;
    d_w = deriv;
    // arithmetic shift gives the floor of the sum, which carries the 24 fraction bits of the q8.24 gains
    sum = (kp_w * e_w + ki_w * i_w + kd_w * d_w) >>> FRAC_BITS;
    res.left = sat_drive(sum);
    res.right = sat_drive(-sum);
    res.werr = err[ERR_W-1:0];
    res.settled = ((err < 0 ? -err : err) <= err_tol) &&
                  ((deriv < 0 ? -deriv : deriv) <= rate_tol);
    if (res.settled) begin
      integral = 0;
      last_err = 0;
    end else begin
      integral = integ;
      last_err = err;
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch_ports
    drive_result_t want, got;
    if (!rst_n) begin
      target_cd = 0;
      kp = KP_RST;
      ki = KI_RST;
      kd = KD_RST;
      err_tol = ERR_TOL_RST;
      rate_tol = RATE_TOL_RST;
      integral = 0;
      last_err = 0;
      expected_drives.delete();
      mismatch_count = 0;
      pending_count <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_ADDR_W-1:2])
          REG_TARGET:   target_cd = $signed(cfg_pwdata[TARGET_W-1:0]);
          REG_KP:       kp = cfg_pwdata[GAIN_W-1:0];
          REG_KI:       ki = cfg_pwdata[GAIN_W-1:0];
          REG_KD:       kd = cfg_pwdata[GAIN_W-1:0];
          REG_ERR_TOL:  err_tol = cfg_pwdata[TOL_W-1:0];
          REG_RATE_TOL: rate_tol = cfg_pwdata[TOL_W-1:0];
          default:      ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = {out_left_drive, out_right_drive, out_wrapped_error, out_settled};
        if (expected_drives.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("drive result %0d arrived with no heading item pending", result_idx);
        end else begin
          want = expected_drives.pop_front();
          if (got.left !== want.left || got.right !== want.right ||
              got.werr !== want.werr || got.settled !== want.settled) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("drive result %0d: expected left %0d right %0d err %0d settled %0b, got left %0d right %0d err %0d settled %0b",
                       result_idx, want.left, want.right, want.werr, want.settled,
                       got.left, got.right, got.werr, got.settled);
          end
        end
        result_idx++;
      end
      if (in_valid && !in_stall)
        expected_drives.push_back(predict_drive(in_heading));
      pending_count <= expected_drives.size();
    end
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives heading items and register writes into the turn controller with
// random idling on both channels; a checker beside the block predicts and
// compares every result and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  import hptc_pkg::*;

  localparam logic [2:0] SPARE_REG_A = 3'd6;
  localparam logic [2:0] SPARE_REG_B = 3'd7;
  localparam int         DRAIN_CYCLES = 10;
  localparam int         PHASE_ITEMS = 36;
  localparam int         WINDUP_ITEMS = 500;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [HEADING_W-1:0]         in_heading = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [DRIVE_W-1:0]    out_left_drive;
  logic signed [DRIVE_W-1:0]    out_right_drive;
  logic signed [ERR_W-1:0]      out_wrapped_error;
  logic                         out_settled;
  logic                         cfg_psel = 1'b0;
  logic                         cfg_penable = 1'b0;
  logic                         cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]        cfg_paddr = '0;
  logic [CFG_DATA_W-1:0]        cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0]        cfg_prdata;
  logic                         cfg_pready;
  int                           mismatch_count;
  int                           pending_count;
  int                           sender_idle_pct = 0;
  int                           receiver_stall_pct = 0;

  heading_pid_turn_controller_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_heading        (in_heading),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_left_drive    (out_left_drive),
    .out_right_drive   (out_right_drive),
    .out_wrapped_error (out_wrapped_error),
    .out_settled       (out_settled),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  hptc_drive_checker drive_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_heading        (in_heading),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_left_drive    (out_left_drive),
    .out_right_drive   (out_right_drive),
    .out_wrapped_error (out_wrapped_error),
    .out_settled       (out_settled),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_pready        (cfg_pready),
    .mismatch_count    (mismatch_count),
    .pending_count     (pending_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // 0: no idling, 1: sender idles, 2: receiver stalls, 3: both now and then
  task automatic set_pace(input int mode);
    case (mode)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 78; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 78; end
      default: begin sender_idle_pct = 6; receiver_stall_pct = 6; end
    endcase
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // narrow registers get random junk above their width
  task automatic program_turn(input int target, input logic [31:0] kp_v,
                              input logic [31:0] ki_v, input logic [31:0] kd_v,
                              input int etol, input int rtol);
    logic [CFG_DATA_W-1:0] word;
    word = $urandom;
    word[TARGET_W-1:0] = target[TARGET_W-1:0];
    cfg_write(REG_TARGET, word);
    cfg_write(REG_KP, kp_v);
    cfg_write(REG_KI, ki_v);
    cfg_write(REG_KD, kd_v);
    word = $urandom;
    word[TOL_W-1:0] = etol[TOL_W-1:0];
    cfg_write(REG_ERR_TOL, word);
    word = $urandom;
    word[TOL_W-1:0] = rtol[TOL_W-1:0];
    cfg_write(REG_RATE_TOL, word);
  endtask

  task automatic send_heading(input logic [HEADING_W-1:0] h);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      in_heading <= HEADING_W'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_heading <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int wrap_turn(input int v);
    return ((v + HALF_TURN) % FULL_TURN + FULL_TURN) % FULL_TURN - HALF_TURN;
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return $urandom;
      3: return $urandom_range(0, 32'h0200_0000);
      default: return $urandom_range(0, 32'h0010_0000);
    endcase
  endfunction

  function automatic int pick_tol(input int usual_max);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 0;
    if (sel == 1) return $urandom_range(0, 32767);
    return $urandom_range(0, usual_max);
  endfunction

  initial begin
    int phase, n, pick, jitter, tgt, cur, step, hd;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default registers: wrap edges, headings past a full turn, settling
    set_pace(0);
    send_heading(16'd0);
    send_heading(16'd0);
    send_heading(16'd35999);
    send_heading(16'd18000);
    send_heading(16'd18001);
    send_heading(16'd17999);
    send_heading(16'hFFFF);
    send_heading(16'd36000);
    send_heading(16'd54000);
    send_heading(16'h8000);
    wait_drained();

    // most negative target, full gains, zero tolerances, spare addresses
    program_turn(-65536, '1, '1, '1, 0, 0);
    cfg_write(SPARE_REG_A, $urandom);
    cfg_write(SPARE_REG_B, $urandom);
    send_heading(16'd0);
    send_heading(16'hFFFF);
    send_heading(16'd1);
    send_heading(16'd30000);
    wait_drained();

    // most positive target, zero gains, widest tolerances
    program_turn(65535, '0, '0, '0, 32767, 32767);
    send_heading(16'd0);
    send_heading(16'hFFFF);
    send_heading(16'd12345);
    send_heading(16'd40000);
    wait_drained();

    program_turn(36000, KP_RST, KI_RST, KD_RST, 18000, 18000);
    send_heading(16'd0);
    send_heading(16'd35999);
    send_heading(16'd18000);
    wait_drained();

    // integral windup drives the sum past the negative end of the 32-bit
    // range, then one settled item clears the loop state
    set_pace(3);
    program_turn(0, '1, '1, '0, 0, 0);
    for (n = 0; n < WINDUP_ITEMS; n++) begin
      hd = 18000 - $urandom_range(0, 50);
      send_heading(hd[HEADING_W-1:0]);
    end
    wait_drained();
    program_turn(0, '1, '1, '0, 32767, 32767);
    send_heading(16'd0);
    wait_drained();

    // random turns: headings close in on the target with jitter, plus noise
    for (phase = 0; phase < 8; phase++) begin
      set_pace(phase % 4);
      if ($urandom_range(0, 9) < 7) begin
        tgt = $urandom_range(0, 72000);
        tgt = tgt - 36000;
      end else begin
        tgt = $urandom_range(0, 131071);
        tgt = tgt - 65536;
      end
      program_turn(tgt, pick_gain(), pick_gain(), pick_gain(), pick_tol(400), pick_tol(60));
      cur = $urandom_range(0, 35999);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          send_heading(HEADING_W'($urandom));
        end else begin
          if (pick < 15) cur = $urandom_range(0, 35999);
          jitter = $urandom_range(0, 20);
          step = wrap_turn(tgt - cur) / 3 + jitter - 10;
          cur = (cur + step + FULL_TURN) % FULL_TURN;
          send_heading(cur[HEADING_W-1:0]);
        end
      end
      wait_drained();
    end

    if (mismatch_count == 0 && pending_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/hptc_pkg.sv
rtl/core/hptc_track.sv
rtl/core/hptc_drive.sv
rtl/core/heading_pid_turn_controller_top.sv
bench/hptc_drive_checker.sv
bench/tb_top.sv
